/* sv/spa_pkg.sv */
// Shared types, constants and codes for the slot pool allocator.
// No dependencies; the datapath, controller, top level and testbench import it.
package spa_pkg;

  localparam int MaxSlots = 64;
  localparam int SlotW = $clog2(MaxSlots);
  localparam int LinkW = SlotW + 1;
  localparam int PoolW = 7;
  localparam int ModeW = 2;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 7;
  localparam int CmdW = 2;
  localparam int StatW = 2;
  localparam int OutSlotW = 6;

  localparam logic [LinkW-1:0] NilLink = LinkW'(MaxSlots);
  localparam logic [PoolW-1:0] PoolMax =
      (64 < MaxSlots) ? PoolW'(64) : PoolW'(MaxSlots);

  localparam logic [CfgIdxW-1:0] RegPoolSize = 1'd0;
  localparam logic [CfgIdxW-1:0] RegOvfMode  = 1'd1;

  localparam logic [CmdW-1:0] CmdAlloc = 2'd0;
  localparam logic [CmdW-1:0] CmdFree  = 2'd1;
  localparam logic [CmdW-1:0] CmdMark  = 2'd2;

  localparam logic [StatW-1:0] StDone    = 2'd0;
  localparam logic [StatW-1:0] StFull    = 2'd1;
  localparam logic [StatW-1:0] StNotAlloc = 2'd2;
  localparam logic [StatW-1:0] StBadIdx  = 2'd3;

  localparam logic [ModeW-1:0] ModeRefuse = 2'd0;
  localparam logic [ModeW-1:0] ModeOldest = 2'd1;

  typedef enum logic [3:0] {
    S_INIT,   // sweep all slots after reset or a pool size write
    S_IDLE,
    S_VSEL,   // take the used head as victim
    S_WALK,   // visit one slot of the allocated list from the tail
    S_RD,     // present the target slot to the link memories
    S_LATCH,  // capture the links of the target slot
    S_UNL_P,  // unlink: fix prev neighbor
    S_UNL_N,  // unlink: fix next neighbor
    S_UNL_S,  // push freed slot onto free list
    S_TK_RD,  // read free head links
    S_TK_H,   // fix old used head
    S_TK_S,   // link granted slot at head
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_INIT_RST,
    OP_LD_CMD,
    OP_SET_TGT,
    OP_RD_SLOT,
    OP_UNL_P,
    OP_UNL_N,
    OP_UNL_S,
    OP_TK_H,
    OP_TK_S
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    op_t             op;
    logic [LinkW-1:0] addr;
    logic            walk_step;
    logic            set_status;
    logic [StatW-1:0] status;
    logic            set_evict;
    logic            set_grant;
    logic            mark_we;
    logic            out_load;
  } spa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [LinkW-1:0] free_head;
    logic [LinkW-1:0] used_head;
    logic [LinkW-1:0] used_tail;
    logic [LinkW-1:0] rd_prev;
    logic            rd_alloc;
    logic            rd_vis;
    logic [LinkW-1:0] init_cnt;
    logic [LinkW-1:0] walk_slot;
    logic [SlotW:0]  walk_steps;
    logic [LinkW-1:0] target;
  } spa_stat_t;

endpackage

/* sv/spa_stream_if.sv */
// Valid/ready channel interface carrying one payload struct.
// Depends on nothing; the payload type is given per instance.
interface spa_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/spa_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
module spa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/spa_datapath.sv */
// Datapath: link memories, per-slot mark bits, list heads and result register.
// Depends on spa_pkg and spa_ram.
module spa_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spa_pkg::spa_cmd_t               cmd,
  input  logic [spa_pkg::SlotW-1:0]       in_slot,
  input  logic                            in_vis,
  input  logic [spa_pkg::PoolW-1:0]       pool_size,
  output spa_pkg::spa_stat_t              stat,
  output logic [spa_pkg::StatW-1:0]       o_status,
  output logic [spa_pkg::OutSlotW-1:0]    o_granted,
  output logic                            o_did_evict,
  output logic [spa_pkg::OutSlotW-1:0]    o_evicted
);
  import spa_pkg::*;

  logic [LinkW-1:0] free_head_r, used_head_r, used_tail_r;
  logic [LinkW-1:0] init_cnt_r, walk_r, tgt_r;
  logic [SlotW:0]   steps_r;
  logic [LinkW-1:0] sv_next_r, sv_prev_r;
  logic [MaxSlots-1:0] alloc_r, vis_r;
  logic [StatW-1:0] status_r;
  logic [SlotW-1:0] grant_r, evict_r;
  logic             did_r;

  logic             nwe, pwe;
  logic [SlotW-1:0] nwa, pwa, ra;
  logic [LinkW-1:0] nwd, pwd, nrd, prd;

  spa_ram #(.Width(LinkW), .Depth(MaxSlots)) u_next (
    .clk(clk), .we(nwe), .waddr(nwa), .wdata(nwd), .raddr(ra), .rdata(nrd));
  spa_ram #(.Width(LinkW), .Depth(MaxSlots)) u_prev (
    .clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(ra), .rdata(prd));

  assign ra = cmd.addr[SlotW-1:0];

  always_comb begin
    nwe = 1'b0; pwe = 1'b0;
    nwa = tgt_r[SlotW-1:0]; pwa = tgt_r[SlotW-1:0];
    nwd = NilLink; pwd = NilLink;
    case (cmd.op)
      OP_INIT: begin
        nwe = 1'b1; pwe = 1'b1;
        nwa = init_cnt_r[SlotW-1:0]; pwa = init_cnt_r[SlotW-1:0];
        nwd = ({1'b0, init_cnt_r} + 1'b1 < {1'b0, LinkW'(pool_size)})
            ? init_cnt_r + 1'b1 : NilLink;
      end
      OP_UNL_P: begin
        nwe = (sv_prev_r != NilLink);
        nwa = sv_prev_r[SlotW-1:0]; nwd = sv_next_r;
      end
      OP_UNL_N: begin
        pwe = (sv_next_r != NilLink);
        pwa = sv_next_r[SlotW-1:0]; pwd = sv_prev_r;
      end
      OP_UNL_S: begin
        nwe = 1'b1; pwe = 1'b1; nwd = free_head_r; pwd = NilLink;
      end
      OP_TK_H: begin
        pwe = (used_head_r != NilLink);
        pwa = used_head_r[SlotW-1:0]; pwd = free_head_r;
      end
      OP_TK_S: begin
        nwe = 1'b1; pwe = 1'b1;
        nwa = free_head_r[SlotW-1:0]; pwa = free_head_r[SlotW-1:0];
        nwd = used_head_r; pwd = NilLink;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0; used_head_r <= NilLink; used_tail_r <= NilLink;
      init_cnt_r <= '0; alloc_r <= '0; vis_r <= '0;
    end else begin
      case (cmd.op)
        OP_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          alloc_r <= '0; vis_r <= '0;
          free_head_r <= '0; used_head_r <= NilLink; used_tail_r <= NilLink;
        end
        OP_INIT_RST: init_cnt_r <= '0;
        OP_LD_CMD: init_cnt_r <= '0;
        OP_UNL_P: if (sv_prev_r == NilLink) used_head_r <= sv_next_r;
        OP_UNL_N: if (sv_next_r == NilLink) used_tail_r <= sv_prev_r;
        OP_UNL_S: begin
          free_head_r <= tgt_r;
          alloc_r[tgt_r[SlotW-1:0]] <= 1'b0;
        end
        OP_TK_H: if (used_head_r == NilLink) used_tail_r <= free_head_r;
        OP_TK_S: begin
          free_head_r <= nrd;
          used_head_r <= free_head_r;
          alloc_r[free_head_r[SlotW-1:0]] <= 1'b1;
        end
        default: ;
      endcase
      if (cmd.mark_we) vis_r[in_slot] <= in_vis;
    end
  end

  // Payload and scratch registers.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LD_CMD) begin
      tgt_r <= {1'b0, in_slot};
      walk_r <= used_tail_r;
      steps_r <= '0;
      status_r <= StDone; grant_r <= '0; evict_r <= '0; did_r <= 1'b0;
    end
    if (cmd.op == OP_SET_TGT) tgt_r <= cmd.addr;
    if (cmd.op == OP_RD_SLOT) begin
      sv_next_r <= nrd; sv_prev_r <= prd; tgt_r <= cmd.addr;
    end
    if (cmd.walk_step) begin
      walk_r <= prd; steps_r <= steps_r + 1'b1;
    end
    if (cmd.set_status) status_r <= cmd.status;
    if (cmd.set_evict) begin
      did_r <= 1'b1; evict_r <= cmd.addr[SlotW-1:0];
    end
    if (cmd.set_grant) grant_r <= free_head_r[SlotW-1:0];
    if (cmd.out_load) begin
      o_status <= status_r; o_granted <= OutSlotW'(grant_r);
      o_did_evict <= did_r; o_evicted <= OutSlotW'(evict_r);
    end
  end

  assign stat.free_head  = free_head_r;
  assign stat.used_head  = used_head_r;
  assign stat.used_tail  = used_tail_r;
  assign stat.rd_prev    = prd;
  assign stat.rd_alloc   = alloc_r[tgt_r[SlotW-1:0]];
  assign stat.rd_vis     = vis_r[walk_r[SlotW-1:0]];
  assign stat.init_cnt   = init_cnt_r;
  assign stat.walk_slot  = walk_r;
  assign stat.walk_steps = steps_r;
  assign stat.target     = tgt_r;

`ifndef SYNTHESIS
  a_head_tail_nil: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LD_CMD |-> (used_head_r == NilLink) == (used_tail_r == NilLink))
    else $error("used head and tail disagree on empty list");
  a_take_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_TK_S |=> alloc_r[$past(free_head_r[SlotW-1:0])])
    else $error("granted slot not marked allocated");
  a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_UNL_S |=> free_head_r == $past(tgt_r))
    else $error("freed slot not at free head");
`endif
endmodule

/* sv/spa_ctrl.sv */
// Controller state machine: sequences init sweep, unlink, victim walk, take.
// Depends on spa_pkg.
module spa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_init,
  input  logic [spa_pkg::ModeW-1:0]  mode,
  input  logic [spa_pkg::PoolW-1:0]  pool_size,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [spa_pkg::CmdW-1:0]   in_command,
  input  logic [spa_pkg::SlotW-1:0]  in_slot,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  spa_pkg::spa_stat_t         stat,
  output spa_pkg::spa_cmd_t          cmd
);
  import spa_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   evict_r, evict_nxt;
  logic   pend_r, pend_nxt;
  logic   walk_end;
  logic   out_of_pool;

  assign walk_end = (stat.walk_slot == NilLink) ||
                    (stat.walk_steps == (SlotW+1)'(MaxSlots));
  assign out_of_pool = ({1'b0, in_slot} >= pool_size);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; ov_r <= 1'b0; evict_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; evict_r <= evict_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    evict_nxt = evict_r;
    pend_nxt = pend_r;
    cmd = '0;
    cmd.op = OP_NONE;
    cmd.addr = stat.target;
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.op = OP_INIT;
        if (stat.init_cnt == LinkW'(MaxSlots - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = (!ov_r || out_ready) && !cfg_init;
        if (in_valid && in_ready) begin
          cmd.op = OP_LD_CMD;
          cmd.set_status = 1'b1;
          cmd.status = StDone;
          evict_nxt = 1'b0;
          case (in_command)
            CmdAlloc: begin
              if (stat.free_head != NilLink) begin
                state_nxt = S_TK_H;
              end else if (mode == ModeRefuse || stat.used_head == NilLink) begin
                cmd.status = StFull;
                pend_nxt = 1'b1; state_nxt = S_OUT;
              end else begin
                evict_nxt = 1'b1;
                if (mode == ModeOldest) begin
                  // Read the tail's prev link now so it is ready in the first walk cycle.
                  cmd.addr = stat.used_tail;
                  state_nxt = S_WALK;
                end else begin
                  state_nxt = S_VSEL;
                end
              end
            end
            CmdFree: begin
              if (out_of_pool) begin
                cmd.status = StBadIdx; state_nxt = S_OUT;
              end else begin
                state_nxt = S_RD;
              end
            end
            CmdMark: begin
              state_nxt = S_OUT;
              if (out_of_pool) cmd.status = StBadIdx;
              else cmd.mark_we = 1'b1;
            end
            default: begin
              cmd.status = StBadIdx; state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_VSEL: begin
        cmd.op = OP_SET_TGT; cmd.addr = stat.used_head; state_nxt = S_RD;
      end
      S_WALK: begin
        // Walk from the tail toward the head; the next prev link is read ahead.
        if (walk_end) begin
          cmd.op = OP_SET_TGT; cmd.addr = stat.used_head; state_nxt = S_RD;
        end else if (!stat.rd_vis) begin
          cmd.op = OP_SET_TGT; cmd.addr = stat.walk_slot; state_nxt = S_RD;
        end else begin
          cmd.walk_step = 1'b1; cmd.addr = stat.rd_prev;
        end
      end
      S_RD: begin
        state_nxt = S_LATCH;
        if (evict_r) begin
          cmd.set_evict = 1'b1;
        end else if (!stat.rd_alloc) begin
          cmd.set_status = 1'b1; cmd.status = StNotAlloc;
          state_nxt = S_OUT;
        end
      end
      S_LATCH: begin
        cmd.op = OP_RD_SLOT; state_nxt = S_UNL_P;
      end
      S_UNL_P: begin
        cmd.op = OP_UNL_P; state_nxt = S_UNL_N;
      end
      S_UNL_N: begin
        cmd.op = OP_UNL_N; state_nxt = S_UNL_S;
      end
      S_UNL_S: begin
        cmd.op = OP_UNL_S;
        state_nxt = evict_r ? S_TK_H : S_OUT;
      end
      S_TK_H: begin
        cmd.op = OP_TK_H; state_nxt = S_TK_RD;
        cmd.addr = stat.free_head;
      end
      S_TK_RD: begin
        cmd.addr = stat.free_head; state_nxt = S_TK_S;
      end
      S_TK_S: begin
        cmd.op = OP_TK_S; cmd.set_grant = 1'b1;
        cmd.addr = stat.free_head;
        evict_nxt = 1'b0; state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1; ov_nxt = 1'b1; pend_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    // A pool size write restarts the sweep from slot zero.
    if (cfg_init) begin
      cmd = '0;
      cmd.op = OP_INIT_RST;
      cmd.addr = stat.target;
      pend_nxt = 1'b0;
      evict_nxt = 1'b0;
      state_nxt = S_INIT;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("input accepted outside idle");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> stat.walk_steps <= (SlotW+1)'(MaxSlots))
    else $error("victim walk ran past pool");
  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_OUT || state_r == S_INIT)
    else $error("refusal pending outside result state");
`endif
endmodule

/* sv/slot_pool_allocator_with_eviction_core.sv */
// Top level of the slot pool allocator with eviction.
// Depends on spa_pkg, spa_stream_if, spa_ctrl, spa_datapath, spa_ram.
//
//  channel | direction | payload
//  in_     | sink      | command, slot_index, visible_value
//  out_    | source    | status, granted_slot, did_evict, evicted_slot
//  cfg_    | write     | cfg_we, cfg_index, cfg_wdata
//
// After acceptance each command (an allocate from the free list, a free, a
// mark, a refusal or bad index, or an eviction of the newest slot) runs until
// its result is loaded; the next transaction is taken after that.
// Evicting the oldest invisible slot walks the allocated list one slot per
// cycle through the prev-link memory, over at most MaxSlots slots.
// After reset or a pool_size write an init sweep rewrites both link memories
// for all MaxSlots slots; no transaction is accepted then.
// A result held in the output register blocks the input until it is taken.
module slot_pool_allocator_with_eviction_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spa_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [spa_pkg::CfgDataW-1:0]  cfg_wdata,
  spa_stream_if.sink                    in_ch,
  spa_stream_if.source                  out_ch
);
  import spa_pkg::*;

  logic [PoolW-1:0] pool_r;
  logic [ModeW-1:0] mode_r;
  logic             cfg_init;
  spa_cmd_t         cmd;
  spa_stat_t        stat;
  logic [PoolW-1:0] wsz;

  always_comb begin
    wsz = cfg_wdata[PoolW-1:0];
    if (wsz == '0) wsz = PoolW'(1);
    if (wsz > PoolMax) wsz = PoolMax;
  end

  assign cfg_init = cfg_we && (cfg_index == RegPoolSize);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= PoolMax; mode_r <= ModeRefuse;
    end else if (cfg_we) begin
      if (cfg_index == RegPoolSize) pool_r <= wsz;
      else if (cfg_index == RegOvfMode) mode_r <= cfg_wdata[ModeW-1:0];
    end
  end

  spa_ctrl u_ctrl (
    .clk, .rst_n, .cfg_init, .mode(mode_r), .pool_size(pool_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.data.command), .in_slot(in_ch.data.slot_index),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .stat, .cmd);

  spa_datapath u_dp (
    .clk, .rst_n, .cmd,
    .in_slot(in_ch.data.slot_index),
    .in_vis(in_ch.data.visible_value), .pool_size(pool_r), .stat,
    .o_status(out_ch.data.status), .o_granted(out_ch.data.granted_slot),
    .o_did_evict(out_ch.data.did_evict), .o_evicted(out_ch.data.evicted_slot));
endmodule

/* tb/tb_slot_pool_allocator_with_eviction_core.sv */
// Testbench for slot_pool_allocator_with_eviction_core: directed and random
// command streams, checked against a predictor of the slot pool kept in SV.
// Depends on spa_pkg, spa_stream_if and the RTL of the allocator.
`timescale 1ns / 100ps

module tb_slot_pool_allocator_with_eviction_core;
  import spa_pkg::*;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [SlotW-1:0] slot_index;
    logic             visible_value;
  } cmd_item_t;

  typedef struct packed {
    logic [StatW-1:0]    status;
    logic [OutSlotW-1:0] granted_slot;
    logic                did_evict;
    logic [OutSlotW-1:0] evicted_slot;
  } alloc_resp_t;

  localparam logic [CmdW-1:0] CmdBad = 2'd3;
  localparam int WatchdogLimit = 4000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  spa_stream_if #(.payload_t(cmd_item_t))   in_ch (clk);
  spa_stream_if #(.payload_t(alloc_resp_t)) out_ch (clk);

  slot_pool_allocator_with_eviction_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // Pool shadow state; null link is MaxSlots.
  logic [LinkW-1:0] nxt_lnk [MaxSlots];
  logic [LinkW-1:0] prv_lnk [MaxSlots];
  logic             alloc_m [MaxSlots];
  logic             vis_m   [MaxSlots];
  logic [LinkW-1:0] free_hd, used_hd, used_tl;
  int               pool_sz;
  logic [ModeW-1:0] ovf_mode;

  cmd_item_t   pending_cmds [$];
  alloc_resp_t expected_resps [$];
  int errors = 0, n_items = 0, n_evicts = 0, n_refused = 0;
  int in_idle_pct = 16, out_idle_pct = 16;
  logic in_fire = 1'b0;
  int quiet_cycles = 0;

  function automatic logic is_slot(logic [LinkW-1:0] s);
    return s < LinkW'(MaxSlots);
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < MaxSlots; i++) begin
      nxt_lnk[i] = NilLink;
      prv_lnk[i] = NilLink;
      alloc_m[i] = 1'b0;
      vis_m[i] = 1'b0;
    end
    for (int i = 0; i + 1 < pool_sz; i++) nxt_lnk[i] = LinkW'(i + 1);
    free_hd = '0;
    used_hd = NilLink;
    used_tl = NilLink;
  endfunction

  function automatic void unlink_slot(logic [LinkW-1:0] s);
    logic [LinkW-1:0] p, n;
    if (!is_slot(s) || !alloc_m[s[SlotW-1:0]]) return;
    p = prv_lnk[s[SlotW-1:0]];
    n = nxt_lnk[s[SlotW-1:0]];
    if (is_slot(p)) nxt_lnk[p[SlotW-1:0]] = n;
    else used_hd = n;
    if (is_slot(n)) prv_lnk[n[SlotW-1:0]] = p;
    else used_tl = p;
    nxt_lnk[s[SlotW-1:0]] = free_hd;
    free_hd = s;
    prv_lnk[s[SlotW-1:0]] = NilLink;
    alloc_m[s[SlotW-1:0]] = 1'b0;
  endfunction

  function automatic logic [LinkW-1:0] choose_victim();
    logic [LinkW-1:0] s;
    s = used_tl;
    if (ovf_mode == ModeOldest) begin
      for (int k = 0; k < MaxSlots && is_slot(s); k++) begin
        if (!vis_m[s[SlotW-1:0]]) return s;
        s = prv_lnk[s[SlotW-1:0]];
      end
    end
    return used_hd;
  endfunction

  function automatic logic [LinkW-1:0] grant_free_head();
    logic [LinkW-1:0] s;
    s = free_hd;
    free_hd = nxt_lnk[s[SlotW-1:0]];
    if (is_slot(used_hd)) prv_lnk[used_hd[SlotW-1:0]] = s;
    else used_tl = s;
    nxt_lnk[s[SlotW-1:0]] = used_hd;
    prv_lnk[s[SlotW-1:0]] = NilLink;
    used_hd = s;
    alloc_m[s[SlotW-1:0]] = 1'b1;
    return s;
  endfunction

  function automatic alloc_resp_t predict_pool_cmd(cmd_item_t c);
    alloc_resp_t r;
    logic [LinkW-1:0] v;
    logic ok;
    r = '0;
    case (c.command)
      CmdAlloc: begin
        ok = 1'b1;
        if (!is_slot(free_hd)) begin
          if (ovf_mode == ModeRefuse || !is_slot(used_hd)) begin
            r.status = StFull;
            ok = 1'b0;
          end else begin
            v = choose_victim();
            unlink_slot(v);
            r.did_evict = 1'b1;
            r.evicted_slot = v[OutSlotW-1:0];
          end
        end
        if (ok && is_slot(free_hd)) begin
          v = grant_free_head();
          r.granted_slot = v[OutSlotW-1:0];
        end else if (ok) begin
          r.status = StFull;
        end
      end
      CmdFree: begin
        if (int'(c.slot_index) >= pool_sz) r.status = StBadIdx;
        else if (!alloc_m[c.slot_index]) r.status = StNotAlloc;
        else unlink_slot({1'b0, c.slot_index});
      end
      CmdMark: begin
        if (int'(c.slot_index) >= pool_sz) r.status = StBadIdx;
        else vis_m[c.slot_index] = c.visible_value;
      end
      default: r.status = StBadIdx;
    endcase
    return r;
  endfunction

  // Driver: a new transaction is presented only once the last one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_fire) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_ch.data <= pending_cmds.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: results are checked before the command of the same edge is applied.
  always @(posedge clk) begin
    alloc_resp_t e, a;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_resps.size() == 0) begin
        $error("unexpected result transaction %p", a);
        errors++;
      end else begin
        e = expected_resps.pop_front();
        if (a.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, a.status);
          errors++;
        end
        if (a.granted_slot !== e.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", e.granted_slot, a.granted_slot);
          errors++;
        end
        if (a.did_evict !== e.did_evict) begin
          $error("did_evict: expected %0d, got %0d", e.did_evict, a.did_evict);
          errors++;
        end
        if (a.evicted_slot !== e.evicted_slot) begin
          $error("evicted_slot: expected %0d, got %0d", e.evicted_slot, a.evicted_slot);
          errors++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      e = predict_pool_cmd(in_ch.data);
      if (e.did_evict) n_evicts++;
      if (e.status == StFull) n_refused++;
      n_items++;
      expected_resps.push_back(e);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    int v;
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == RegPoolSize) begin
      v = int'(val);
      if (v == 0) v = 1;
      if (v > MaxSlots) v = MaxSlots;
      pool_sz = v;
      clear_pool();
    end else begin
      ovf_mode = val[ModeW-1:0];
    end
  endtask

  // Holds the sender until every result is back, then lets the block settle.
  task automatic drain();
    while (pending_cmds.size() > 0 || expected_resps.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic push_cmd(logic [CmdW-1:0] c, int s, logic vis);
    cmd_item_t it;
    it.command = c;
    it.slot_index = SlotW'(s);
    it.visible_value = vis;
    pending_cmds.push_back(it);
  endtask

  // Frees and marks mostly target slots inside the pool; indexes sometimes leave it.
  task automatic push_random(int n);
    int r, s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      s = ($urandom_range(9) == 0) ? $urandom_range(MaxSlots - 1)
                                   : $urandom_range(pool_sz - 1);
      if (r < 45) push_cmd(CmdAlloc, $urandom_range(MaxSlots - 1), 1'($urandom_range(1)));
      else if (r < 75) push_cmd(CmdFree, s, 1'($urandom_range(1)));
      else if (r < 96) push_cmd(CmdMark, s, 1'($urandom_range(1)));
      else push_cmd(CmdBad, $urandom_range(MaxSlots - 1), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int sizes [8] = '{0, 1, 2, 3, 127, 64, 5, 100};
    pool_sz = int'(PoolMax);
    ovf_mode = ModeRefuse;
    clear_pool();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Small pool: fill, refuse, bad index, double free, unknown command.
    write_reg(RegPoolSize, 7'd4);
    for (int i = 0; i < 5; i++) push_cmd(CmdAlloc, 0, 1'b0);
    push_cmd(CmdFree, 4, 1'b0);
    push_cmd(CmdFree, 63, 1'b1);
    push_cmd(CmdFree, 1, 1'b0);
    push_cmd(CmdFree, 1, 1'b0);
    push_cmd(CmdMark, 63, 1'b1);
    push_cmd(CmdBad, 2, 1'b1);
    push_cmd(CmdAlloc, 63, 1'b1);
    drain();

    // Oldest invisible eviction, then fallback to newest with all visible.
    write_reg(RegOvfMode, CfgDataW'(ModeOldest));
    push_cmd(CmdMark, 3, 1'b1);
    push_cmd(CmdAlloc, 0, 1'b0);
    for (int i = 0; i < 4; i++) push_cmd(CmdMark, i, 1'b1);
    push_cmd(CmdAlloc, 0, 1'b0);
    drain();
    write_reg(RegOvfMode, CfgDataW'(3));
    push_cmd(CmdAlloc, 0, 1'b0);
    push_cmd(CmdMark, 0, 1'b0);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      write_reg(RegPoolSize, (ph < 8) ? CfgDataW'(sizes[ph])
                                      : CfgDataW'($urandom_range(1, 64)));
      write_reg(RegOvfMode, CfgDataW'(ph % 4));
      if (ph == 5) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = 16;
        out_idle_pct = 16;
      end
      push_random(56);
      drain();
    end

    $display("covered %0d commands over 17 pool size settings, all overflow modes",
             n_items);
    $display("%0d allocations evicted a slot, %0d were refused", n_evicts, n_refused);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* slot_pool_allocator_with_eviction_core.f */
sv/spa_pkg.sv
sv/spa_stream_if.sv
sv/spa_ram.sv
sv/spa_datapath.sv
sv/spa_ctrl.sv
sv/slot_pool_allocator_with_eviction_core.sv
tb/tb_slot_pool_allocator_with_eviction_core.sv
